>>> hdl/u32u16_pkg.sv
// Shared types and constants for the UTF-32 to UTF-16 stream encoder.
// No dependencies; every other file in this folder imports this package.
package u32u16_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int CP_W            = 32;
  localparam int UNIT_W          = 16;
  localparam int CNT_OUT_W       = 32;

  localparam logic [CP_W-1:0]   SURR_MASK   = 32'h001F_F800;
  localparam logic [CP_W-1:0]   SURR_BASE   = 32'h0000_D800;
  localparam logic [UNIT_W-1:0] NONCHAR_LO  = 16'hFDD0;
  localparam logic [UNIT_W-1:0] NONCHAR_HI  = 16'hFDEF;
  localparam logic [CP_W-1:0]   CP_LIMIT    = 32'h0011_0000;
  localparam logic [UNIT_W-1:0] HIGH_OFFSET = 16'hD800 - 16'h0040;
  localparam logic [5:0]        LOW_TAG     = 6'b110111;

  typedef enum logic [1:0] {
    STATUS_CONT,
    STATUS_DONE,
    STATUS_INVALID,
    STATUS_NO_SPACE
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VALIDATE,
    REG_COUNT_ONLY,
    REG_STOP_NUL,
    REG_CAPACITY
  } reg_index_t;

  typedef struct packed {
    logic                  validate_enable;
    logic                  count_only;
    logic                  stop_at_nul;
    logic [CFG_DATA_W-1:0] out_capacity;
  } cfg_t;

  typedef struct packed {
    logic [UNIT_W-1:0]    code_unit;
    logic                 unit_valid;
    logic                 run_last;
    status_t              status;
    logic [CNT_OUT_W-1:0] consumed_count;
    logic [CNT_OUT_W-1:0] produced_count;
    logic [1:0]           space_shortfall;
  } result_t;

  typedef struct packed {
    logic [1:0] num_results;
    result_t    first;
    result_t    second;
  } enc_out_t;

endpackage

>>> hdl/utf32_to_utf16_stream_encoder.sv
// Top level of the UTF-32 to UTF-16 stream encoder: input register, run
// counters, result register with a second-half holding register.
// Depends on u32u16_pkg and u32u16_encode.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     code_point, last_item
//   result    out        out_valid / out_stall   code_unit .. space_shortfall
//   config    in         cfg_write               cfg_index, cfg_data
//
// One word is accepted per cycle when not stalled; it and its result are each registered.
// A surrogate pair's second half waits in the holding register, and a word that gives a result stalls meanwhile.
// Count-only words that give no result pass at one per cycle even while the result is stalled.
// Reset is synchronous: config and valid bits take their defaults and both counts clear.
module utf32_to_utf16_stream_encoder #(
  parameter int COUNT_WIDTH = u32u16_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [u32u16_pkg::CP_W-1:0]         code_point,
  input  logic                                last_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [u32u16_pkg::UNIT_W-1:0]       code_unit,
  output logic                                unit_valid,
  output logic                                run_last,
  output logic [1:0]                          status,
  output logic [u32u16_pkg::CNT_OUT_W-1:0]    consumed_count,
  output logic [u32u16_pkg::CNT_OUT_W-1:0]    produced_count,
  output logic [1:0]                          space_shortfall,
  input  logic                                cfg_write,
  input  logic [u32u16_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [u32u16_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import u32u16_pkg::*;

  cfg_t                   cfg;
  logic                   s1_valid;
  logic [CP_W-1:0]        s1_cp;
  logic                   s1_last;
  logic                   pend_valid;
  result_t                pend;
  logic                   oreg_valid;
  result_t                oreg;
  logic [COUNT_WIDTH-1:0] words;
  logic [COUNT_WIDTH-1:0] units;
  logic [COUNT_WIDTH-1:0] words_next;
  logic [COUNT_WIDTH-1:0] units_next;
  enc_out_t               step;
  logic                   has_results;
  logic                   oreg_free;
  logic                   s1_fire;
  logic                   load_pend;
  logic                   load_s1;

  u32u16_encode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_encode (
    .cfg       (cfg),
    .code_point(s1_cp),
    .last_item (s1_last),
    .words     (words),
    .units     (units),
    .words_next(words_next),
    .units_next(units_next),
    .step      (step)
  );

  assign has_results = step.num_results != 2'd0;
  assign oreg_free   = !oreg_valid || !out_stall;
  assign s1_fire     = s1_valid && (!has_results || (oreg_free && !pend_valid));
  assign in_stall    = s1_valid && !s1_fire;
  assign load_pend   = oreg_free && pend_valid;
  assign load_s1     = oreg_free && !pend_valid && s1_fire && has_results;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.validate_enable <= 1'b1;
      cfg.count_only      <= 1'b0;
      cfg.stop_at_nul     <= 1'b0;
      cfg.out_capacity    <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_VALIDATE:   cfg.validate_enable <= cfg_data[0];
        REG_COUNT_ONLY: cfg.count_only      <= cfg_data[0];
        REG_STOP_NUL:   cfg.stop_at_nul     <= cfg_data[0];
        REG_CAPACITY:   cfg.out_capacity    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      oreg_valid <= 1'b0;
      words      <= '0;
      units      <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        words <= words_next;
        units <= units_next;
      end
      if (oreg_free) begin
        oreg_valid <= load_pend || load_s1;
      end
      if (load_pend) begin
        pend_valid <= 1'b0;
      end else if (s1_fire && step.num_results == 2'd2) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cp   <= code_point;
      s1_last <= last_item;
    end
    if (load_pend) begin
      oreg <= pend;
    end else if (load_s1) begin
      oreg <= step.first;
    end
    if (s1_fire && step.num_results == 2'd2) begin
      pend <= step.second;
    end
  end

  assign out_valid       = oreg_valid;
  assign code_unit       = oreg.code_unit;
  assign unit_valid      = oreg.unit_valid;
  assign run_last        = oreg.run_last;
  assign status          = oreg.status;
  assign consumed_count  = oreg.consumed_count;
  assign produced_count  = oreg.produced_count;
  assign space_shortfall = oreg.space_shortfall;

endmodule

>>> hdl/u32u16_encode.sv
// Validation, capacity check and surrogate encoding for one UTF-32 word.
// Purely combinational; depends on u32u16_pkg.
module u32u16_encode #(
  parameter int COUNT_WIDTH = u32u16_pkg::COUNT_WIDTH_DEF
) (
  input  u32u16_pkg::cfg_t              cfg,
  input  logic [u32u16_pkg::CP_W-1:0]   code_point,
  input  logic                          last_item,
  input  logic [COUNT_WIDTH-1:0]        words,
  input  logic [COUNT_WIDTH-1:0]        units,
  output logic [COUNT_WIDTH-1:0]        words_next,
  output logic [COUNT_WIDTH-1:0]        units_next,
  output u32u16_pkg::enc_out_t          step
);
  import u32u16_pkg::*;

  localparam int XW = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

  function automatic result_t mk(input logic [UNIT_W-1:0] unit, input logic valid,
                                 input logic last, input status_t st,
                                 input logic [CNT_OUT_W-1:0] wc,
                                 input logic [CNT_OUT_W-1:0] uc,
                                 input logic [1:0] sf);
    result_t r;
    r.code_unit       = unit;
    r.unit_valid      = valid;
    r.run_last        = last;
    r.status          = st;
    r.consumed_count  = wc;
    r.produced_count  = uc;
    r.space_shortfall = sf;
    return r;
  endfunction

  logic                   bmp;
  logic                   rsrv;
  logic                   bad;
  logic                   nul;
  logic                   term;
  logic                   cap_ge;
  logic                   one_left;
  logic                   no_space;
  logic [1:0]             need;
  logic [1:0]             shortfall;
  logic [UNIT_W-1:0]      u0;
  logic [UNIT_W-1:0]      u1;
  logic [COUNT_WIDTH-1:0] words_inc;
  logic [COUNT_WIDTH-1:0] units_inc;
  logic [XW-1:0]          units_x;
  logic [XW-1:0]          cap_x;
  logic [XW-1:0]          diff_x;
  logic [XW-1:0]          words_ox;
  logic [XW-1:0]          units_ox;
  logic [XW-1:0]          words_ix;
  logic [XW-1:0]          units_ix;

  assign bmp  = code_point[CP_W-1:UNIT_W] == '0;
  assign rsrv = code_point[UNIT_W-1:1] == '1;
  assign need = bmp ? 2'd1 : 2'd2;

  always_comb begin
    if (bmp) begin
      bad = ((code_point & SURR_MASK) == SURR_BASE) ||
            ((code_point[UNIT_W-1:0] >= NONCHAR_LO) &&
             (code_point[UNIT_W-1:0] <= NONCHAR_HI)) || rsrv;
    end else begin
      bad = (code_point >= CP_LIMIT) || rsrv;
    end
    bad = bad && cfg.validate_enable;
  end

  assign units_x   = XW'(units);
  assign cap_x     = XW'(cfg.out_capacity);
  assign cap_ge    = units_x >= cap_x;
  assign diff_x    = cap_x - units_x;
  assign one_left  = diff_x == XW'(1);
  assign no_space  = !cfg.count_only && (cap_ge || (one_left && !bmp));
  assign shortfall = cap_ge ? need : 2'd1;

  assign u0 = bmp ? code_point[UNIT_W-1:0] : code_point[25:10] + HIGH_OFFSET;
  assign u1 = {LOW_TAG, code_point[9:0]};

  assign nul  = cfg.stop_at_nul && (code_point == '0);
  assign term = !cfg.stop_at_nul && last_item;

  assign words_inc = words + COUNT_WIDTH'(1);
  assign units_inc = units + COUNT_WIDTH'(need);
  assign words_ox  = XW'(words);
  assign units_ox  = XW'(units);
  assign words_ix  = XW'(words_inc);
  assign units_ix  = XW'(units_inc);

  always_comb begin
    step        = '0;
    words_next  = words;
    units_next  = units;
    if (bad) begin
      step.num_results = 2'd1;
      step.first = mk('0, 1'b0, 1'b1, STATUS_INVALID, words_ox[CNT_OUT_W-1:0],
                      units_ox[CNT_OUT_W-1:0], 2'd0);
      words_next = '0;
      units_next = '0;
    end else if (no_space) begin
      step.num_results = 2'd1;
      step.first = mk('0, 1'b0, 1'b1, STATUS_NO_SPACE, words_ox[CNT_OUT_W-1:0],
                      units_ox[CNT_OUT_W-1:0], shortfall);
      words_next = '0;
      units_next = '0;
    end else if (nul) begin
      // In count-only mode the terminating NUL is counted as a unit.
      step.num_results = 2'd1;
      if (cfg.count_only) begin
        step.first = mk('0, 1'b0, 1'b1, STATUS_DONE, words_ox[CNT_OUT_W-1:0],
                        units_ix[CNT_OUT_W-1:0], 2'd0);
      end else begin
        step.first = mk('0, 1'b1, 1'b1, STATUS_DONE, words_ox[CNT_OUT_W-1:0],
                        units_ox[CNT_OUT_W-1:0], 2'd0);
      end
      words_next = '0;
      units_next = '0;
    end else if (cfg.count_only) begin
      if (term) begin
        step.num_results = 2'd1;
        step.first = mk('0, 1'b0, 1'b1, STATUS_DONE, words_ix[CNT_OUT_W-1:0],
                        units_ix[CNT_OUT_W-1:0], 2'd0);
        words_next = '0;
        units_next = '0;
      end else begin
        words_next = words_inc;
        units_next = units_inc;
      end
    end else if (bmp) begin
      step.num_results = 2'd1;
      if (term) begin
        step.first = mk(u0, 1'b1, 1'b1, STATUS_DONE, words_ix[CNT_OUT_W-1:0],
                        units_ix[CNT_OUT_W-1:0], 2'd0);
        words_next = '0;
        units_next = '0;
      end else begin
        step.first = mk(u0, 1'b1, 1'b1, STATUS_CONT, '0, '0, 2'd0);
        words_next = words_inc;
        units_next = units_inc;
      end
    end else begin
      step.num_results = 2'd2;
      step.first = mk(u0, 1'b1, 1'b0, STATUS_CONT, '0, '0, 2'd0);
      if (term) begin
        step.second = mk(u1, 1'b1, 1'b1, STATUS_DONE, words_ix[CNT_OUT_W-1:0],
                         units_ix[CNT_OUT_W-1:0], 2'd0);
        words_next = '0;
        units_next = '0;
      end else begin
        step.second = mk(u1, 1'b1, 1'b1, STATUS_CONT, '0, '0, 2'd0);
        words_next = words_inc;
        units_next = units_inc;
      end
    end
  end

endmodule

>>> hdl/u32u16_checker.sv
// Port-level checks for the UTF-32 to UTF-16 stream encoder, bound to the top level.
// Depends on u32u16_pkg.
module u32u16_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [u32u16_pkg::UNIT_W-1:0]       code_unit,
  input logic                                unit_valid,
  input logic                                run_last,
  input logic [1:0]                          status,
  input logic [u32u16_pkg::CNT_OUT_W-1:0]    consumed_count,
  input logic [u32u16_pkg::CNT_OUT_W-1:0]    produced_count,
  input logic [1:0]                          space_shortfall
);
  import u32u16_pkg::*;

  // A stalled result holds its unit until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_unit))
    else $error("result changed while stalled");

  a_final_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_CONT) |-> run_last)
    else $error("terminating status on a non-final result");

  a_shortfall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == STATUS_NO_SPACE) == (space_shortfall != 2'd0)))
    else $error("shortfall does not match status");

  a_first_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> unit_valid && (status == STATUS_CONT))
    else $error("first half of a pair is malformed");

  a_counts_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_CONT) |-> (consumed_count == '0) && (produced_count == '0))
    else $error("counts reported on a continuing result");

endmodule

bind utf32_to_utf16_stream_encoder u32u16_checker u_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for the UTF-32 to UTF-16 stream encoder: a directed table
// then randomised runs, checked by a behavioural encoder here or a row's own want.
// Depends on u32u16_pkg and utf32_to_utf16_stream_encoder.
`timescale 1ns / 1ps

module tb_top;
  import u32u16_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 210;

  typedef struct {
    bit          is_write;
    reg_index_t  index;
    logic [31:0] value;
    logic        last;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CP_W-1:0]        code_point = '0;
  logic                   last_item = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [UNIT_W-1:0]      code_unit;
  logic                   unit_valid;
  logic                   run_last;
  logic [1:0]             status;
  logic [CNT_OUT_W-1:0]   consumed_count;
  logic [CNT_OUT_W-1:0]   produced_count;
  logic [1:0]             space_shortfall;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  cfg_t        enc_cfg;
  logic [31:0] words_in_run;
  logic [31:0] units_in_run;
  result_t     word_units[$];
  result_t     pending_units[$];
  stim_row_t   directed_rows[$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  words_sent = 0;
  int  units_checked = 0;
  int  runs_closed = 0;
  int  invalid_ends = 0;
  int  no_space_ends = 0;
  int  hold_request = 0;
  bit  burst = 1'b0;
  bit  calm = 1'b0;

  utf32_to_utf16_stream_encoder uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .code_point(code_point), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_unit(code_unit), .unit_valid(unit_valid), .run_last(run_last),
    .status(status), .consumed_count(consumed_count),
    .produced_count(produced_count), .space_shortfall(space_shortfall),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
    mismatches++;
  endtask

  // Ends the current run with one result carrying both counts, then clears them.
  task automatic close_run(input logic [15:0] unit, input logic valid, input status_t st,
                           input logic [1:0] shortfall);
    result_t r;
    r.code_unit = unit;
    r.unit_valid = valid;
    r.run_last = 1'b1;
    r.status = st;
    r.consumed_count = words_in_run;
    r.produced_count = units_in_run;
    r.space_shortfall = shortfall;
    word_units.push_back(r);
    words_in_run = '0;
    units_in_run = '0;
    runs_closed++;
    if (st == STATUS_INVALID) invalid_ends++;
    if (st == STATUS_NO_SPACE) no_space_ends++;
  endtask

  task automatic emit_unit(input logic [15:0] unit, input logic is_last);
    result_t r;
    r = '0;
    r.code_unit = unit;
    r.unit_valid = 1'b1;
    r.run_last = is_last;
    r.status = STATUS_CONT;
    word_units.push_back(r);
  endtask

  // Works out the results that one accepted word causes and advances the counts.
  task automatic encode_word(input logic [31:0] cp, input logic last);
    logic        bmp, reserved, bad, ends_run;
    logic [63:0] need, avail;
    logic [15:0] high_half, low_half;
    bmp = cp < 32'h0001_0000;
    reserved = (cp & 32'h0000_FFFE) == 32'h0000_FFFE;
    need = bmp ? 64'd1 : 64'd2;
    word_units.delete();
    if (enc_cfg.validate_enable) begin
      if (bmp)
        bad = ((cp & SURR_MASK) == SURR_BASE) ||
              (cp >= 32'(NONCHAR_LO) && cp <= 32'(NONCHAR_HI)) || reserved;
      else
        bad = (cp >= CP_LIMIT) || reserved;
      if (bad) begin
        close_run('0, 1'b0, STATUS_INVALID, 2'd0);
        return;
      end
    end
    if (!enc_cfg.count_only) begin
      avail = (64'(enc_cfg.out_capacity) > 64'(units_in_run)) ?
              64'(enc_cfg.out_capacity) - 64'(units_in_run) : 64'd0;
      if (avail < need) begin
        close_run('0, 1'b0, STATUS_NO_SPACE, 2'(need - avail));
        return;
      end
    end
    high_half = 16'((cp >> 10) + 32'(HIGH_OFFSET));
    low_half = {LOW_TAG, cp[9:0]};
    if (enc_cfg.stop_at_nul && cp == 32'd0) begin
      if (enc_cfg.count_only) begin
        units_in_run = units_in_run + 32'd1;
        close_run('0, 1'b0, STATUS_DONE, 2'd0);
      end else begin
        close_run('0, 1'b1, STATUS_DONE, 2'd0);
      end
      return;
    end
    words_in_run = words_in_run + 32'd1;
    units_in_run = units_in_run + 32'(need);
    ends_run = !enc_cfg.stop_at_nul && last;
    if (enc_cfg.count_only) begin
      if (ends_run) close_run('0, 1'b0, STATUS_DONE, 2'd0);
    end else if (bmp) begin
      if (ends_run) close_run(cp[15:0], 1'b1, STATUS_DONE, 2'd0);
      else emit_unit(cp[15:0], 1'b1);
    end else begin
      emit_unit(high_half, 1'b0);
      if (ends_run) close_run(low_half, 1'b1, STATUS_DONE, 2'd0);
      else emit_unit(low_half, 1'b1);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_code_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 32'h0000_D7FF);
    if (r < 55) return $urandom_range(32'h0000_E000, 32'h0000_FFFD);
    if (r < 75) return $urandom_range(32'h0001_0000, 32'h0010_FFFD);
    if (r < 80) return 32'd0;
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return $urandom_range(32'h0000_D800, 32'h0000_DFFF);
        1: return $urandom_range(32'(NONCHAR_LO), 32'(NONCHAR_HI));
        2: return ($urandom_range(0, 16) << 16) | 32'h0000_FFFE | $urandom_range(0, 1);
        3: return $urandom_range(32'(CP_LIMIT), 32'h001F_FFFF);
        default: return $urandom_range(32'(CP_LIMIT), 32'hFFFF_FFFF);
      endcase
    end
    return $urandom();
  endfunction

  // Offers one word, waits for its transfer, then records what it should produce.
  task automatic send_word(input logic [31:0] cp, input logic last, input bit typed,
                           input result_t want);
    int gap;
    in_valid <= 1'b1;
    code_point <= cp;
    last_item <= last;
    do @(posedge clk); while (in_stall);
    encode_word(cp, last);
    if (typed) pending_units.push_back(want);
    else foreach (word_units[i]) pending_units.push_back(word_units[i]);
    words_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_VALIDATE:   enc_cfg.validate_enable = value[0];
      REG_COUNT_ONLY: enc_cfg.count_only = value[0];
      REG_STOP_NUL:   enc_cfg.stop_at_nul = value[0];
      REG_CAPACITY:   enc_cfg.out_capacity = value;
      default: ;
    endcase
  endtask

  function automatic stim_row_t word_row(input logic [31:0] cp, input logic last);
    stim_row_t row;
    row.is_write = 1'b0;
    row.index = REG_VALIDATE;
    row.value = cp;
    row.last = last;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // A word that ends a fresh run at once, so both counts read zero.
  function automatic stim_row_t ending_row(input logic [31:0] cp, input status_t st,
                                           input logic [1:0] shortfall);
    stim_row_t row;
    row = word_row(cp, 1'b0);
    row.typed = 1'b1;
    row.want.run_last = 1'b1;
    row.want.status = st;
    row.want.space_shortfall = shortfall;
    return row;
  endfunction

  function automatic stim_row_t write_row(input reg_index_t idx, input logic [31:0] value);
    stim_row_t row;
    row = word_row(value, 1'b0);
    row.is_write = 1'b1;
    row.index = idx;
    return row;
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.code_unit = code_unit;
      got.unit_valid = unit_valid;
      got.run_last = run_last;
      got.status = status_t'(status);
      got.consumed_count = consumed_count;
      got.produced_count = produced_count;
      got.space_shortfall = space_shortfall;
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected result, code_unit", got.code_unit, '0);
      end else begin
        want = pending_units.pop_front();
        units_checked++;
        if (got.code_unit !== want.code_unit)
          report_mismatch("code_unit", got.code_unit, want.code_unit);
        if (got.unit_valid !== want.unit_valid)
          report_mismatch("unit_valid", got.unit_valid, want.unit_valid);
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", got.run_last, want.run_last);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.consumed_count !== want.consumed_count)
          report_mismatch("consumed_count", got.consumed_count, want.consumed_count);
        if (got.produced_count !== want.produced_count)
          report_mismatch("produced_count", got.produced_count, want.produced_count);
        if (got.space_shortfall !== want.space_shortfall)
          report_mismatch("space_shortfall", got.space_shortfall, want.space_shortfall);
      end
    end
  end

  // The receiver stalls in stretches of random length, and for one long hold on request.
  initial begin : receiver
    int r, n;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        n = hold_request;
        hold_request = 0;
      end else if (calm || r < 50) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 12);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] cap;
    enc_cfg.validate_enable = 1'b1;
    enc_cfg.count_only = 1'b0;
    enc_cfg.stop_at_nul = 1'b0;
    enc_cfg.out_capacity = '0;
    words_in_run = '0;
    units_in_run = '0;

    directed_rows.push_back(ending_row(32'h0000_0041, STATUS_NO_SPACE, 2'd1));
    directed_rows.push_back(ending_row(32'h0001_0000, STATUS_NO_SPACE, 2'd2));
    directed_rows.push_back(ending_row(32'h0000_D800, STATUS_INVALID, 2'd0));
    directed_rows.push_back(write_row(REG_CAPACITY, 32'hFFFF_FFFF));
    directed_rows.push_back(word_row(32'h0000_0000, 1'b0));
    directed_rows.push_back(word_row(32'h0000_FFFD, 1'b0));
    directed_rows.push_back(word_row(32'h0001_0000, 1'b0));
    directed_rows.push_back(word_row(32'h0010_FFFD, 1'b1));
    directed_rows.push_back(ending_row(32'h0000_DFFF, STATUS_INVALID, 2'd0));
    directed_rows.push_back(ending_row(32'h0000_FDD0, STATUS_INVALID, 2'd0));
    directed_rows.push_back(ending_row(32'h0000_FDEF, STATUS_INVALID, 2'd0));
    directed_rows.push_back(ending_row(32'h0001_FFFE, STATUS_INVALID, 2'd0));
    directed_rows.push_back(ending_row(32'h0011_0000, STATUS_INVALID, 2'd0));
    directed_rows.push_back(ending_row(32'hFFFF_FFFF, STATUS_INVALID, 2'd0));
    directed_rows.push_back(write_row(REG_VALIDATE, 32'd0));
    directed_rows.push_back(word_row(32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(word_row(32'h0000_D800, 1'b1));
    directed_rows.push_back(write_row(REG_COUNT_ONLY, 32'd1));
    directed_rows.push_back(word_row(32'h0001_0000, 1'b0));
    directed_rows.push_back(word_row(32'h0000_0041, 1'b1));
    directed_rows.push_back(write_row(REG_STOP_NUL, 32'd1));
    directed_rows.push_back(word_row(32'h0000_0041, 1'b1));
    directed_rows.push_back(word_row(32'h0000_0000, 1'b0));
    directed_rows.push_back(write_row(REG_COUNT_ONLY, 32'd0));
    directed_rows.push_back(word_row(32'h0000_20AC, 1'b0));
    directed_rows.push_back(word_row(32'h0000_0000, 1'b1));
    directed_rows.push_back(write_row(REG_VALIDATE, 32'd1));
    directed_rows.push_back(write_row(REG_CAPACITY, 32'd2));
    directed_rows.push_back(word_row(32'h0000_0041, 1'b0));
    directed_rows.push_back(word_row(32'h0001_0000, 1'b0));
    directed_rows.push_back(word_row(32'h0001_0000, 1'b0));
    directed_rows.push_back(write_row(REG_CAPACITY, 32'd1));
    directed_rows.push_back(word_row(32'h0000_0041, 1'b0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write)
        write_reg(directed_rows[i].index, directed_rows[i].value);
      else
        send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 2:    cap = 32'hFFFF_FFFF;
        3:       cap = 32'd0;
        5:       cap = $urandom();
        default: cap = $urandom_range(1, 40);
      endcase
      write_reg(REG_VALIDATE, (p == 1 || p == 5) ? 32'd0 : 32'd1);
      write_reg(REG_COUNT_ONLY, (p == 3 || p == 6) ? 32'd1 : 32'd0);
      write_reg(REG_STOP_NUL, (p == 2 || p == 6 || p == 7) ? 32'd1 : 32'd0);
      write_reg(REG_CAPACITY, cap);
      calm = (p == 7);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == 2 && k == 100) begin
          hold_request = 100;
          burst = 1'b1;
        end
        if (p == 2 && k == 160) burst = 1'b0;
        if (p == 4 && k == 150) settle();
        send_word(pick_code_point(), $urandom_range(0, 15) == 0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d words over %0d runs; %0d results checked", words_sent, runs_closed,
             units_checked);
    $display("runs ended on invalid words: %0d, on lack of space: %0d", invalid_ends,
             no_space_ends);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
